[design/grdfs_pkg.sv]
// ----------------------------------------------------------------------------
// grdfs_pkg
// Shared types and sizes for the graph reachability block.
// ----------------------------------------------------------------------------
package grdfs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_DEGREE   = 8;
    localparam int TABLE_DEPTH  = MAX_VERTICES * MAX_DEGREE;
    localparam int STACK_DEPTH  = TABLE_DEPTH + 1;

    localparam int VTX_W   = 6;                          // field width of a vertex number
    localparam int VIDX_W  = $clog2(MAX_VERTICES);       // index into per-vertex stores
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);     // holds 0..MAX_DEGREE
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);    // holds 0..STACK_DEPTH

    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } in_item_t;

    typedef struct packed {
        logic reachable;
        logic status;
    } out_item_t;

    // Requests from the sequencer to the adjacency store
    typedef struct packed {
        logic [VIDX_W-1:0] deg_rd_addr;
        logic              deg_wr_en;
        logic [VIDX_W-1:0] deg_wr_addr;
        logic [DEG_W-1:0]  deg_wr_data;
        logic [TBL_AW-1:0] tbl_rd_addr;
        logic              tbl_wr_en;
        logic [TBL_AW-1:0] tbl_wr_addr;
        logic [VTX_W-1:0]  tbl_wr_data;
    } adj_req_t;

    // Requests from the sequencer to the search stack
    typedef struct packed {
        logic              wr_en;
        logic [STK_AW-1:0] wr_addr;
        logic [VTX_W-1:0]  wr_data;
        logic [STK_AW-1:0] rd_addr;
    } stk_req_t;

    function automatic logic vtx_in_range(input logic [VTX_W-1:0] v);
        return ({1'b0, v} < (VTX_W+1)'(MAX_VERTICES));
    endfunction

    function automatic logic [VIDX_W-1:0] vtx_idx(input logic [VTX_W-1:0] v);
        return VIDX_W'(v);
    endfunction

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [VTX_W-1:0] v,
                                                   input logic [DEG_W-1:0] k);
        return TBL_AW'(v) * TBL_AW'(MAX_DEGREE) + TBL_AW'(k);
    endfunction

endpackage

[design/grdfs_adj.sv]
// ----------------------------------------------------------------------------
// grdfs_adj
// Adjacency store: degree counts with per-entry valid bits, and the
// neighbour table. One read and one write port each, registered reads.
// ----------------------------------------------------------------------------
module grdfs_adj (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  grdfs_pkg::adj_req_t            req,
    output logic [grdfs_pkg::DEG_W-1:0]    deg_rd,
    output logic [grdfs_pkg::VTX_W-1:0]    tbl_rd
);
    import grdfs_pkg::*;

    logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [DEG_W-1:0]        deg_q_reg;
    logic                    deg_v_reg;

    logic [VTX_W-1:0]        tbl_mem [TABLE_DEPTH];
    logic [VTX_W-1:0]        tbl_q_reg;

    always_ff @(posedge aclk) begin
        if (req.deg_wr_en) begin
            deg_mem[req.deg_wr_addr] <= req.deg_wr_data;
        end
        deg_q_reg <= deg_mem[req.deg_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_vld_reg <= '0;
            deg_v_reg   <= 1'b0;
        end else begin
            if (req.deg_wr_en) begin
                deg_vld_reg[req.deg_wr_addr] <= 1'b1;
            end
            deg_v_reg <= deg_vld_reg[req.deg_rd_addr];
        end
    end

    // an entry never written reads as zero
    assign deg_rd = deg_v_reg ? deg_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (req.tbl_wr_en) begin
            tbl_mem[req.tbl_wr_addr] <= req.tbl_wr_data;
        end
        tbl_q_reg <= tbl_mem[req.tbl_rd_addr];
    end

    assign tbl_rd = tbl_q_reg;

endmodule

[design/grdfs_stack.sv]
// ----------------------------------------------------------------------------
// grdfs_stack
// Search stack storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module grdfs_stack (
    input  logic                         aclk,
    input  grdfs_pkg::stk_req_t          req,
    output logic [grdfs_pkg::VTX_W-1:0]  rd_data
);
    import grdfs_pkg::*;

    logic [VTX_W-1:0] stk_mem [STACK_DEPTH];
    logic [VTX_W-1:0] rd_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            stk_mem[req.wr_addr] <= req.wr_data;
        end
        rd_q_reg <= stk_mem[req.rd_addr];
    end

    assign rd_data = rd_q_reg;

endmodule

[design/graph_reachability_dfs_top.sv]
// ----------------------------------------------------------------------------
// graph_reachability_dfs_top
// Undirected graph store with depth-first reachability queries.
// ----------------------------------------------------------------------------
// An edge item (mode 0) appends each endpoint to the other's neighbour list
// and returns status 1 without changing anything if a list lacks room. A
// query item (mode 1) clears the visited marks and walks the graph with a
// stack from vertex_a, answering reachable as soon as vertex_b is popped.
// A pop passes through ST_Q_POP and ST_Q_TOP; a vertex expanded then passes
// through ST_Q_DEG and ST_Q_NBR, which reads one neighbour entry a cycle
// from the neighbour table's single read port. One item is in flight at a
// time: s_ready is high only while the sequencer is idle and out of reset.
// Each item gives one result, held in an output register until taken.
// ----------------------------------------------------------------------------
module graph_reachability_dfs_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  grdfs_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output grdfs_pkg::out_item_t  m_data
);
    import grdfs_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_E_RDB = 4'd1;
    localparam logic [3:0] ST_E_CHK = 4'd2;
    localparam logic [3:0] ST_E_WR2 = 4'd3;
    localparam logic [3:0] ST_Q_POP = 4'd4;
    localparam logic [3:0] ST_Q_TOP = 4'd5;
    localparam logic [3:0] ST_Q_DEG = 4'd6;
    localparam logic [3:0] ST_Q_NBR = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [VTX_W-1:0]        op_a_reg, op_a_next;
    logic [VTX_W-1:0]        op_b_reg, op_b_next;
    logic [DEG_W-1:0]        deg_a_reg, deg_a_next;
    logic [DEG_W-1:0]        deg_b_reg, deg_b_next;
    logic [VTX_W-1:0]        cur_reg, cur_next;
    logic [DEG_W-1:0]        k_reg, k_next;
    logic [LVL_W-1:0]        level_reg, level_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    out_item_t               res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    adj_req_t          adj_req;
    stk_req_t          stk_req;
    logic [DEG_W-1:0]  deg_rd;
    logic [VTX_W-1:0]  tbl_rd;
    logic [VTX_W-1:0]  stk_rd;

    logic                    accept;
    logic [DEG_W:0]          deg_a_plus2;
    logic                    edge_full;
    logic [DEG_W-1:0]        deg_a_inc;

    grdfs_adj u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (adj_req),
        .deg_rd  (deg_rd),
        .tbl_rd  (tbl_rd)
    );

    grdfs_stack u_stack (
        .aclk    (aclk),
        .req     (stk_req),
        .rd_data (stk_rd)
    );

    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign deg_a_inc   = deg_a_reg + DEG_W'(1);
    assign deg_a_plus2 = {1'b0, deg_a_reg} + (DEG_W+1)'(2);
    // self loop needs two free slots in the one list
    assign edge_full = (op_a_reg == op_b_reg)
                     ? (deg_a_plus2 > (DEG_W+1)'(MAX_DEGREE))
                     : ((deg_a_reg >= DEG_W'(MAX_DEGREE)) || (deg_rd >= DEG_W'(MAX_DEGREE)));

    always_comb begin
        state_next   = state_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        deg_a_next   = deg_a_reg;
        deg_b_next   = deg_b_reg;
        cur_next     = cur_reg;
        k_next       = k_reg;
        level_next   = level_reg;
        visited_next = visited_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        adj_req = '0;
        stk_req = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_a_next = s_data.vertex_a;
                    op_b_next = s_data.vertex_b;
                    res_next  = '0;
                    if (s_data.mode == MODE_EDGE) begin
                        if (!vtx_in_range(s_data.vertex_a) || !vtx_in_range(s_data.vertex_b)) begin
                            res_next.status = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            adj_req.deg_rd_addr = vtx_idx(s_data.vertex_a);
                            state_next          = ST_E_RDB;
                        end
                    end else begin
                        visited_next = '0;
                        level_next   = '0;
                        if (!vtx_in_range(s_data.vertex_a) || !vtx_in_range(s_data.vertex_b)) begin
                            state_next = ST_DONE;
                        end else begin
                            stk_req.wr_en   = 1'b1;
                            stk_req.wr_addr = '0;
                            stk_req.wr_data = s_data.vertex_a;
                            level_next      = LVL_W'(1);
                            state_next      = ST_Q_POP;
                        end
                    end
                end
            end

            ST_E_RDB: begin
                deg_a_next          = deg_rd;
                adj_req.deg_rd_addr = vtx_idx(op_b_reg);
                state_next          = ST_E_CHK;
            end

            ST_E_CHK: begin
                if (edge_full) begin
                    res_next.status = STATUS_FULL;
                    state_next      = ST_DONE;
                end else begin
                    adj_req.tbl_wr_en   = 1'b1;
                    adj_req.tbl_wr_addr = tbl_addr(op_a_reg, deg_a_reg);
                    adj_req.tbl_wr_data = op_b_reg;
                    adj_req.deg_wr_en   = 1'b1;
                    adj_req.deg_wr_addr = vtx_idx(op_a_reg);
                    adj_req.deg_wr_data = deg_a_inc;
                    deg_b_next = (op_a_reg == op_b_reg) ? deg_a_inc : deg_rd;
                    state_next = ST_E_WR2;
                end
            end

            ST_E_WR2: begin
                adj_req.tbl_wr_en   = 1'b1;
                adj_req.tbl_wr_addr = tbl_addr(op_b_reg, deg_b_reg);
                adj_req.tbl_wr_data = op_a_reg;
                adj_req.deg_wr_en   = 1'b1;
                adj_req.deg_wr_addr = vtx_idx(op_b_reg);
                adj_req.deg_wr_data = deg_b_reg + DEG_W'(1);
                res_next.status     = STATUS_OK;
                state_next          = ST_DONE;
            end

            ST_Q_POP: begin
                if (level_reg == '0) begin
                    res_next.reachable = 1'b0;
                    level_next         = '0;
                    state_next         = ST_DONE;
                end else begin
                    stk_req.rd_addr = STK_AW'(level_reg - LVL_W'(1));
                    state_next      = ST_Q_TOP;
                end
            end

            ST_Q_TOP: begin
                if (stk_rd == op_b_reg) begin
                    res_next.reachable = 1'b1;
                    level_next         = '0;
                    state_next         = ST_DONE;
                end else begin
                    level_next = level_reg - LVL_W'(1);
                    if (!vtx_in_range(stk_rd) || visited_reg[vtx_idx(stk_rd)]) begin
                        state_next = ST_Q_POP;
                    end else begin
                        visited_next[vtx_idx(stk_rd)] = 1'b1;
                        cur_next            = stk_rd;
                        adj_req.deg_rd_addr = vtx_idx(stk_rd);
                        state_next          = ST_Q_DEG;
                    end
                end
            end

            ST_Q_DEG: begin
                deg_a_next          = deg_rd;
                k_next              = '0;
                adj_req.tbl_rd_addr = tbl_addr(cur_reg, '0);
                state_next          = ST_Q_NBR;
            end

            ST_Q_NBR: begin
                // tbl_rd holds entry k of the current vertex's list
                if ((k_reg < deg_a_reg) && (k_reg < DEG_W'(MAX_DEGREE))) begin
                    if (vtx_in_range(tbl_rd) && !visited_reg[vtx_idx(tbl_rd)]
                        && (level_reg < LVL_W'(STACK_DEPTH))) begin
                        stk_req.wr_en   = 1'b1;
                        stk_req.wr_addr = STK_AW'(level_reg);
                        stk_req.wr_data = tbl_rd;
                        level_next      = level_reg + LVL_W'(1);
                    end
                    k_next              = k_reg + DEG_W'(1);
                    adj_req.tbl_rd_addr = tbl_addr(cur_reg, k_reg + DEG_W'(1));
                end else begin
                    state_next = ST_Q_POP;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            visited_reg <= visited_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        deg_a_reg  <= deg_a_next;
        deg_b_reg  <= deg_b_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

[sim/graph_reachability_dfs_top_tb.sv]
// ----------------------------------------------------------------------------
// graph_reachability_dfs_top_tb
// Self-checking bench for the graph reachability block: a directed table of
// edge and query items, then random items drawn around moving vertex
// clusters, scored against a built-in model of the neighbour lists and the
// depth-first search, or against a directed row's literal answer. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module graph_reachability_dfs_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grdfs_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 300;

    localparam out_item_t NOT_FOUND = '{reachable: 1'b0, status: STATUS_OK};
    localparam out_item_t FOUND     = '{reachable: 1'b1, status: STATUS_OK};
    localparam out_item_t EDGE_OK   = '{reachable: 1'b0, status: STATUS_OK};
    localparam out_item_t EDGE_FULL = '{reachable: 1'b0, status: STATUS_FULL};

    typedef struct packed {
        logic             mode;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic             typed;   // 1: use the literal answer below
        out_item_t        want;
    } row_t;

    localparam int N_ROWS = 25;

    row_t directed [N_ROWS] = '{
        '{MODE_QUERY, 6'd0,  6'd1,  1'b1, NOT_FOUND},  // empty graph
        '{MODE_QUERY, 6'd5,  6'd5,  1'b1, FOUND},      // start is goal, no edges
        '{MODE_QUERY, 6'd63, 6'd63, 1'b1, FOUND},
        '{MODE_EDGE,  6'd0,  6'd63, 1'b1, EDGE_OK},
        '{MODE_QUERY, 6'd0,  6'd63, 1'b1, FOUND},
        '{MODE_QUERY, 6'd63, 6'd0,  1'b1, FOUND},
        '{MODE_EDGE,  6'd63, 6'd42, 1'b0, EDGE_OK},
        '{MODE_QUERY, 6'd0,  6'd42, 1'b0, FOUND},
        '{MODE_EDGE,  6'd42, 6'd0,  1'b0, EDGE_OK},    // closes a triangle
        '{MODE_QUERY, 6'd42, 6'd1,  1'b0, NOT_FOUND},  // cycle forces revisits
        '{MODE_EDGE,  6'd20, 6'd20, 1'b0, EDGE_OK},    // self loops fill vertex 20
        '{MODE_EDGE,  6'd20, 6'd20, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd20, 6'd20, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd20, 6'd20, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd20, 6'd20, 1'b1, EDGE_FULL},
        '{MODE_EDGE,  6'd20, 6'd30, 1'b1, EDGE_FULL},
        '{MODE_EDGE,  6'd30, 6'd20, 1'b1, EDGE_FULL},
        '{MODE_QUERY, 6'd20, 6'd30, 1'b0, NOT_FOUND},
        '{MODE_EDGE,  6'd40, 6'd40, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd40, 6'd40, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd40, 6'd40, 1'b0, EDGE_OK},
        '{MODE_EDGE,  6'd40, 6'd41, 1'b0, EDGE_OK},    // degree now 7
        '{MODE_EDGE,  6'd40, 6'd40, 1'b1, EDGE_FULL},  // self loop needs two slots
        '{MODE_QUERY, 6'd41, 6'd40, 1'b0, FOUND},
        '{MODE_QUERY, 6'd20, 6'd20, 1'b0, FOUND}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // model of the block's graph and search state
    int degree_cnt [MAX_VERTICES];
    int nbr_list   [TABLE_DEPTH];
    bit seen       [MAX_VERTICES];
    int dfs_stack  [STACK_DEPTH];
    int dfs_depth;

    out_item_t pending_results [$];
    int        n_errors   = 0;
    int        n_taken    = 0;

    graph_reachability_dfs_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic link_vertices(int a, int b);
        if (a >= MAX_VERTICES || b >= MAX_VERTICES)
            return STATUS_FULL;
        if (a == b) begin
            if (degree_cnt[a] + 2 > MAX_DEGREE)
                return STATUS_FULL;
        end else if (degree_cnt[a] >= MAX_DEGREE || degree_cnt[b] >= MAX_DEGREE) begin
            return STATUS_FULL;
        end
        nbr_list[a * MAX_DEGREE + degree_cnt[a]] = b;
        degree_cnt[a]++;
        nbr_list[b * MAX_DEGREE + degree_cnt[b]] = a;
        degree_cnt[b]++;
        return STATUS_OK;
    endfunction

    function automatic void stack_vertex(int v);
        if (dfs_depth < STACK_DEPTH) begin
            dfs_stack[dfs_depth] = v;
            dfs_depth++;
        end
    endfunction

    function automatic logic path_exists(int start, int goal);
        int  u;
        int  w;
        logic hit;
        hit = 1'b0;
        foreach (seen[i]) seen[i] = 1'b0;
        dfs_depth = 0;
        if (start >= MAX_VERTICES || goal >= MAX_VERTICES)
            return 1'b0;
        stack_vertex(start);
        while (dfs_depth > 0) begin
            u = dfs_stack[dfs_depth - 1];
            if (u == goal) begin
                hit = 1'b1;
                break;
            end
            dfs_depth--;
            if (u >= MAX_VERTICES || seen[u])
                continue;
            seen[u] = 1'b1;
            for (int k = 0; k < degree_cnt[u] && k < MAX_DEGREE; k++) begin
                w = nbr_list[u * MAX_DEGREE + k];
                if (w < MAX_VERTICES && !seen[w])
                    stack_vertex(w);
            end
        end
        dfs_depth = 0;
        return hit;
    endfunction

    function automatic out_item_t graph_response(in_item_t it);
        out_item_t r;
        r = EDGE_OK;
        if (it.mode == MODE_EDGE)
            r.status = link_vertices(int'(it.vertex_a), int'(it.vertex_b));
        else
            r.reachable = path_exists(int'(it.vertex_a), int'(it.vertex_b));
        return r;
    endfunction

    // three picks in four fall in a 16-vertex window that moves every 100 items
    function automatic logic [VTX_W-1:0] pick_vertex(int n);
        int base;
        base = ((n / 100) * 16) % MAX_VERTICES;
        if ($urandom_range(0, 3) == 0)
            return VTX_W'($urandom_range(0, 2**VTX_W - 1));
        return VTX_W'(base + $urandom_range(0, 15));
    endfunction

    function automatic void note_error(string msg);
        if (n_errors < 10)
            $display("%0t: %s", $realtime, msg);
        n_errors++;
    endfunction

    task automatic offer(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t exp_r;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        exp_r = graph_response(it);
        pending_results = {pending_results, (typed ? want : exp_r)};
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // result side
    initial begin
        out_item_t got;
        out_item_t want;
        int        stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (n_taken == 150)
                stall = HOLD_CYCLES;
            else if (n_taken >= 250 && n_taken < 320)
                stall = 0;
            else
                stall = $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            got = m_data;
            @(posedge aclk);
            n_taken++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result r=%0b s=%0b",
                                     got.reachable, got.status));
            end else begin
                want = pending_results.pop_front();
                if (got.reachable !== want.reachable)
                    note_error($sformatf("result %0d reachable: exp %0b got %0b",
                                         n_taken, want.reachable, got.reachable));
                if (got.status !== want.status)
                    note_error($sformatf("result %0d status: exp %0b got %0b",
                                         n_taken, want.status, got.status));
            end
        end
    end

    // item side and end of run
    initial begin
        in_item_t it;
        int       gap;
        foreach (degree_cnt[i]) degree_cnt[i] = 0;
        dfs_depth = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            it = '{mode: directed[i].mode, vertex_a: directed[i].a,
                   vertex_b: directed[i].b};
            offer(it, directed[i].typed, directed[i].want);
            sender_gap($urandom_range(0, 3));
        end
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it.mode     = ($urandom_range(0, 99) < 40) ? MODE_EDGE : MODE_QUERY;
            it.vertex_a = pick_vertex(n);
            it.vertex_b = pick_vertex(n);
            offer(it, 1'b0, EDGE_OK);
            if (n == 300) begin
                drain_results();
            end else begin
                gap = (n >= 200 && n < 270) ? 0 : $urandom_range(0, 3);
                sender_gap(gap);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (pending_results.size() != 0)
            note_error("expected results never arrived");
        if (n_errors == 0)
            $display("graph_reachability_dfs_top_tb passed");
        else
            $display("graph_reachability_dfs_top_tb failed");
        $finish;
    end

    // end the run as failed if it never finishes
    initial begin
        #30_000_000;
        $display("graph_reachability_dfs_top_tb failed");
        $finish;
    end

endmodule
